// ===== sv/flr_pkg.sv =====
// Package with shared types, constants and codes of the floor drift leveler.
package flr_pkg;

  localparam int WINDOW_MAX_DEF  = 16;
  localparam int COORD_WIDTH_DEF = 32;

  localparam int FIELD_W    = 32;
  localparam int WIN_W      = 5;
  localparam int THR_W      = 24;
  localparam int SEP_W      = 31;
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;
  // thr is Q8.16, so thr squared carries 32 fraction bits.
  localparam int FRAC_SHIFT = 32;

  localparam logic [WIN_W-1:0] WIN_RST = 5'd8;
  localparam logic [THR_W-1:0] THR_RST = 24'd6554;
  localparam logic [SEP_W-1:0] SEP_RST = 31'd32768;

  localparam logic [2:0] REG_WINDOW  = 3'd0;
  localparam logic [2:0] REG_THRESH  = 3'd1;
  localparam logic [2:0] REG_MIN_SEP = 3'd2;
  localparam logic [2:0] REG_START_X = 3'd3;
  localparam logic [2:0] REG_START_Y = 3'd4;
  localparam logic [2:0] REG_START_Z = 3'd5;

  typedef enum logic [3:0] {
    MS_DX, MS_DY, MS_DZ, MS_SEP, MS_HX, MS_HY, MS_VZ, MS_THR, MS_HT
  } mul_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL_GO, ST_MUL_WAIT, ST_DECIDE, ST_CHECK, ST_RD_SEC, ST_SEC,
    ST_TEST, ST_SH_RD, ST_SH_WR, ST_DROP, ST_DONE
  } state_e;

  typedef struct packed {
    logic [WIN_W-1:0]    window_length;
    logic [THR_W-1:0]    grad_limit;
    logic [SEP_W-1:0]    keep_gap;
    logic [2:0]          start_we;
    logic [FIELD_W-1:0]  start_val;
  } cfg_t;

  typedef struct packed {
    logic     load_in;
    logic     mul_start;
    logic     mul_store;
    mul_sel_e sel;
    logic     keep;
    logic     rd_sec;
    logic     sec_load;
    logic     shift_init;
    logic     sh_wr;
    logic     drop;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_busy;
    logic keep_ok;
    logic full;
    logic pass;
    logic sh_more;
  } dp_sts_t;

  typedef struct packed {
    logic load;
    logic kept;
    logic emitted;
  } res_t;

endpackage

// ===== sv/flr_cfg.sv =====
// APB register file holding the leveler configuration.
module flr_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel_i,
  input  logic                             penable_i,
  input  logic                             pwrite_i,
  input  logic [flr_pkg::APB_ADDR_W-1:0]   paddr_i,
  input  logic [flr_pkg::APB_DATA_W-1:0]   pwdata_i,
  output logic [flr_pkg::APB_DATA_W-1:0]   prdata_o,
  output flr_pkg::cfg_t                    cfg_o
);

  logic                          we;
  logic [2:0]                    idx;
  logic [flr_pkg::WIN_W-1:0]     win_q;
  logic [flr_pkg::THR_W-1:0]     thr_q;
  logic [flr_pkg::SEP_W-1:0]     sep_q;
  logic [flr_pkg::FIELD_W-1:0]   sx_q, sy_q, sz_q;

  assign we  = psel_i & penable_i & pwrite_i;
  assign idx = paddr_i[flr_pkg::APB_ADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= flr_pkg::WIN_RST;
      thr_q <= flr_pkg::THR_RST;
      sep_q <= flr_pkg::SEP_RST;
      sx_q  <= '0;
      sy_q  <= '0;
      sz_q  <= '0;
    end else if (we) begin
      case (idx)
        flr_pkg::REG_WINDOW:  win_q <= pwdata_i[flr_pkg::WIN_W-1:0];
        flr_pkg::REG_THRESH:  thr_q <= pwdata_i[flr_pkg::THR_W-1:0];
        flr_pkg::REG_MIN_SEP: sep_q <= pwdata_i[flr_pkg::SEP_W-1:0];
        flr_pkg::REG_START_X: sx_q  <= pwdata_i;
        flr_pkg::REG_START_Y: sy_q  <= pwdata_i;
        flr_pkg::REG_START_Z: sz_q  <= pwdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      flr_pkg::REG_WINDOW:  prdata_o = 32'(win_q);
      flr_pkg::REG_THRESH:  prdata_o = 32'(thr_q);
      flr_pkg::REG_MIN_SEP: prdata_o = 32'(sep_q);
      flr_pkg::REG_START_X: prdata_o = sx_q;
      flr_pkg::REG_START_Y: prdata_o = sy_q;
      flr_pkg::REG_START_Z: prdata_o = sz_q;
      default:              prdata_o = '0;
    endcase
  end

  always_comb begin
    cfg_o.window_length   = win_q;
    cfg_o.grad_limit      = thr_q;
    cfg_o.keep_gap        = sep_q;
    cfg_o.start_we[0]     = we && (idx == flr_pkg::REG_START_X);
    cfg_o.start_we[1]     = we && (idx == flr_pkg::REG_START_Y);
    cfg_o.start_we[2]     = we && (idx == flr_pkg::REG_START_Z);
    cfg_o.start_val       = pwdata_i;
  end

endmodule

// ===== sv/flr_ctrl.sv =====
// Controller state machine sequencing the leveler datapath.
module flr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              out_free_i,
  input  flr_pkg::dp_sts_t  sts_i,
  output flr_pkg::dp_cmd_t  cmd_o,
  output flr_pkg::res_t     res_o
);

  flr_pkg::state_e   state_q, state_d;
  flr_pkg::mul_sel_e sel_q, sel_d;
  logic              kept_q, kept_d, emit_q, emit_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= flr_pkg::ST_IDLE;
      sel_q   <= flr_pkg::MS_DX;
      kept_q  <= 1'b0;
      emit_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
      kept_q  <= kept_d;
      emit_q  <= emit_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    sel_d         = sel_q;
    kept_d        = kept_q;
    emit_d        = emit_q;
    cmd_o         = '0;
    cmd_o.sel     = sel_q;
    res_o         = '0;
    res_o.kept    = kept_q;
    res_o.emitted = emit_q;
    in_ready_o    = 1'b0;
    case (state_q)
      flr_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          sel_d         = flr_pkg::MS_DX;
          state_d       = flr_pkg::ST_MUL_GO;
        end
      end
      flr_pkg::ST_MUL_GO: begin
        cmd_o.mul_start = 1'b1;
        state_d         = flr_pkg::ST_MUL_WAIT;
      end
      flr_pkg::ST_MUL_WAIT: begin
        if (!sts_i.mul_busy) begin
          cmd_o.mul_store = 1'b1;
          if (sel_q == flr_pkg::MS_SEP) begin
            state_d = flr_pkg::ST_DECIDE;
          end else if (sel_q == flr_pkg::MS_HT) begin
            state_d = flr_pkg::ST_TEST;
          end else begin
            sel_d   = flr_pkg::mul_sel_e'(sel_q + 4'd1);
            state_d = flr_pkg::ST_MUL_GO;
          end
        end
      end
      flr_pkg::ST_DECIDE: begin
        kept_d = 1'b0;
        emit_d = 1'b0;
        if (sts_i.keep_ok) begin
          cmd_o.keep = 1'b1;
          kept_d     = 1'b1;
          state_d    = flr_pkg::ST_CHECK;
        end else begin
          state_d = flr_pkg::ST_DONE;
        end
      end
      flr_pkg::ST_CHECK: begin
        state_d = sts_i.full ? flr_pkg::ST_RD_SEC : flr_pkg::ST_DONE;
      end
      flr_pkg::ST_RD_SEC: begin
        cmd_o.rd_sec = 1'b1;
        state_d      = flr_pkg::ST_SEC;
      end
      flr_pkg::ST_SEC: begin
        cmd_o.sec_load = 1'b1;
        sel_d          = flr_pkg::MS_HX;
        state_d        = flr_pkg::ST_MUL_GO;
      end
      flr_pkg::ST_TEST: begin
        if (sts_i.pass) begin
          cmd_o.shift_init = 1'b1;
          state_d          = flr_pkg::ST_SH_RD;
        end else begin
          state_d = flr_pkg::ST_DROP;
        end
      end
      flr_pkg::ST_SH_RD: begin
        state_d = sts_i.sh_more ? flr_pkg::ST_SH_WR : flr_pkg::ST_DROP;
      end
      flr_pkg::ST_SH_WR: begin
        cmd_o.sh_wr = 1'b1;
        state_d     = flr_pkg::ST_SH_RD;
      end
      flr_pkg::ST_DROP: begin
        cmd_o.drop = 1'b1;
        emit_d     = 1'b1;
        state_d    = flr_pkg::ST_DONE;
      end
      flr_pkg::ST_DONE: begin
        if (out_free_i) begin
          res_o.load = 1'b1;
          state_d    = flr_pkg::ST_IDLE;
        end
      end
      default: state_d = flr_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== sv/flr_dp.sv =====
// Leveler datapath: track memory, point registers and a shift-add multiplier.
module flr_dp #(
  parameter int WindowMax  = flr_pkg::WINDOW_MAX_DEF,
  parameter int CoordWidth = flr_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  flr_pkg::cfg_t                 cfg_i,
  input  flr_pkg::dp_cmd_t              cmd_i,
  input  logic [flr_pkg::FIELD_W-1:0]   in_x_i,
  input  logic [flr_pkg::FIELD_W-1:0]   in_y_i,
  input  logic [flr_pkg::FIELD_W-1:0]   in_z_i,
  output flr_pkg::dp_sts_t              sts_o,
  output logic [flr_pkg::FIELD_W-1:0]   rel_x_o,
  output logic [flr_pkg::FIELD_W-1:0]   rel_y_o,
  output logic [flr_pkg::FIELD_W-1:0]   rel_z_o
);

  localparam int CW   = CoordWidth;
  localparam int D    = CW + 1;
  localparam int MA   = 2 * D + 1;
  localparam int MB   = (D > 2 * flr_pkg::THR_W) ? D : 2 * flr_pkg::THR_W;
  localparam int PW   = MA + MB;
  localparam int DW   = (2 * D + 2 > 2 * flr_pkg::SEP_W) ? 2 * D + 2 : 2 * flr_pkg::SEP_W;
  localparam int TW   = 2 * flr_pkg::THR_W;
  localparam int AW   = (WindowMax > 1) ? $clog2(WindowMax) : 1;
  localparam int CNW  = $clog2(WindowMax + 1);
  localparam int MW   = 3 * CW;
  localparam logic signed [CW+1:0] SatHi = (CW+2)'((64'sd1 <<< (CW - 1)) - 64'sd1);
  localparam logic signed [CW+1:0] SatLo = ~SatHi;

  function automatic logic [D-1:0] mag(input logic [CW-1:0] a, input logic [CW-1:0] b);
    logic [D-1:0] d;
    d = {a[CW-1], a} - {b[CW-1], b};
    return d[D-1] ? (~d + 1'b1) : d;
  endfunction

  function automatic logic [AW-1:0] idx(input logic [AW-1:0] head, input logic [CNW-1:0] k);
    logic [AW:0] s;
    s = {1'b0, head} + (AW+1)'(CNW'(k - 1'b1));
    if (s >= (AW+1)'(WindowMax)) s = s - (AW+1)'(WindowMax);
    return s[AW-1:0];
  endfunction

  function automatic logic [CW-1:0] sat(input logic signed [CW+1:0] s);
    if (s > SatHi) return SatHi[CW-1:0];
    if (s < SatLo) return SatLo[CW-1:0];
    return s[CW-1:0];
  endfunction

  logic signed [CW-1:0] px_q, py_q, pz_q;
  logic signed [CW-1:0] anc_x_q, anc_y_q, anc_z_q;
  logic signed [CW-1:0] last_x_q, last_y_q, last_z_q;
  logic signed [CW-1:0] sec_x_q, sec_y_q, sec_z_q;
  logic signed [CW-1:0] rel_x_q, rel_y_q, rel_z_q;
  logic [CNW-1:0]       count_q, k_q;
  logic [AW-1:0]        head_q, waddr, raddr;
  logic [CW:0]          shift_q, shift_w;
  logic [MW-1:0]        mem_q [WindowMax];
  logic [MW-1:0]        rdata_q, wdata;
  logic                 mem_we;
  logic [PW-1:0]        a_q, acc_q;
  logic [MB-1:0]        b_q;
  logic [MA-1:0]        a_n;
  logic [MB-1:0]        b_n;
  logic [DW-1:0]        dist_q, lim_q;
  logic [MA-1:0]        hsum_q;
  logic [2*D-1:0]       vsq_q;
  logic [TW-1:0]        tsq_q;
  logic                 pass_q;
  logic [CNW-1:0]       winc;
  logic [CW-1:0]        lx, ly, lz, rx, ry, rz, rz_sh;
  logic [D-1:0]         mdx, mdy, mdz, mhx, mhy, mvz;

  // The last kept point is the anchor while the track holds it alone.
  assign lx = (count_q == CNW'(1)) ? anc_x_q : last_x_q;
  assign ly = (count_q == CNW'(1)) ? anc_y_q : last_y_q;
  assign lz = (count_q == CNW'(1)) ? anc_z_q : last_z_q;

  assign mdx = mag(px_q, lx);
  assign mdy = mag(py_q, ly);
  assign mdz = mag(pz_q, lz);
  assign mhx = mag(px_q, sec_x_q);
  assign mhy = mag(py_q, sec_y_q);
  assign mvz = mag(pz_q, sec_z_q);

  assign rx = rdata_q[CW-1:0];
  assign ry = rdata_q[2*CW-1:CW];
  assign rz = rdata_q[3*CW-1:2*CW];
  assign rz_sh = sat({{2{rz[CW-1]}}, rz} + {shift_q[CW], shift_q});
  assign shift_w = {anc_z_q[CW-1], anc_z_q} - {sec_z_q[CW-1], sec_z_q};

  always_comb begin
    if (cfg_i.window_length < 5'd2) begin
      winc = CNW'(2);
    end else if (32'(cfg_i.window_length) > 32'(WindowMax)) begin
      winc = CNW'(WindowMax);
    end else begin
      winc = CNW'(cfg_i.window_length);
    end
  end

  always_comb begin
    case (cmd_i.sel)
      flr_pkg::MS_DX:  begin a_n = MA'(mdx); b_n = MB'(mdx); end
      flr_pkg::MS_DY:  begin a_n = MA'(mdy); b_n = MB'(mdy); end
      flr_pkg::MS_DZ:  begin a_n = MA'(mdz); b_n = MB'(mdz); end
      flr_pkg::MS_SEP: begin
        a_n = MA'(cfg_i.keep_gap);
        b_n = MB'(cfg_i.keep_gap);
      end
      flr_pkg::MS_HX:  begin a_n = MA'(mhx); b_n = MB'(mhx); end
      flr_pkg::MS_HY:  begin a_n = MA'(mhy); b_n = MB'(mhy); end
      flr_pkg::MS_VZ:  begin a_n = MA'(mvz); b_n = MB'(mvz); end
      flr_pkg::MS_THR: begin
        a_n = MA'(cfg_i.grad_limit);
        b_n = MB'(cfg_i.grad_limit);
      end
      flr_pkg::MS_HT:  begin a_n = hsum_q; b_n = MB'(tsq_q); end
      default:         begin a_n = '0; b_n = '0; end
    endcase
  end

  // Shift-add multiplier: one multiplier bit per cycle, done once b runs out of ones.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_q <= '0;
    end else if (cmd_i.mul_start) begin
      b_q <= b_n;
    end else if (b_q != '0) begin
      b_q <= b_q >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_start) begin
      a_q   <= PW'(a_n);
      acc_q <= '0;
    end else if (b_q != '0) begin
      a_q <= a_q << 1;
      if (b_q[0]) acc_q <= acc_q + a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_store) begin
      case (cmd_i.sel)
        flr_pkg::MS_DX:  dist_q <= DW'(acc_q);
        flr_pkg::MS_DY:  dist_q <= dist_q + DW'(acc_q);
        flr_pkg::MS_DZ:  dist_q <= dist_q + DW'(acc_q);
        flr_pkg::MS_SEP: lim_q  <= DW'(acc_q);
        flr_pkg::MS_HX:  hsum_q <= MA'(acc_q);
        flr_pkg::MS_HY:  hsum_q <= hsum_q + MA'(acc_q);
        flr_pkg::MS_VZ:  vsq_q  <= (2*D)'(acc_q);
        flr_pkg::MS_THR: tsq_q  <= TW'(acc_q);
        flr_pkg::MS_HT:  pass_q <= (PW'({vsq_q, {flr_pkg::FRAC_SHIFT{1'b0}}}) < acc_q);
        default: ;
      endcase
    end
  end

  // Track memory holds the points after the anchor, oldest at head_q.
  assign mem_we = cmd_i.keep | cmd_i.sh_wr;
  assign waddr  = cmd_i.keep ? idx(head_q, count_q) : idx(head_q, k_q);
  assign wdata  = cmd_i.keep ? {pz_q, py_q, px_q} : {rz_sh, ry, rx};
  assign raddr  = cmd_i.rd_sec ? head_q : idx(head_q, k_q);

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[waddr] <= wdata;
    rdata_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      px_q <= CW'($signed(in_x_i));
      py_q <= CW'($signed(in_y_i));
      pz_q <= CW'($signed(in_z_i));
    end
    if (cmd_i.keep) begin
      last_x_q <= px_q;
      last_y_q <= py_q;
      last_z_q <= pz_q;
    end else if (cmd_i.shift_init) begin
      last_z_q <= sat({{2{last_z_q[CW-1]}}, last_z_q} + {shift_w[CW], shift_w});
    end
    if (cmd_i.sec_load) begin
      sec_x_q <= rx;
      sec_y_q <= ry;
      sec_z_q <= rz;
    end
    if (cmd_i.shift_init) begin
      shift_q <= shift_w;
      k_q     <= CNW'(2);
    end else if (cmd_i.sh_wr) begin
      k_q <= k_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      anc_x_q <= '0;
      anc_y_q <= '0;
      anc_z_q <= '0;
      rel_x_q <= '0;
      rel_y_q <= '0;
      rel_z_q <= '0;
      count_q <= CNW'(1);
      head_q  <= '0;
    end else begin
      if (cfg_i.start_we[0]) anc_x_q <= CW'($signed(cfg_i.start_val));
      if (cfg_i.start_we[1]) anc_y_q <= CW'($signed(cfg_i.start_val));
      if (cfg_i.start_we[2]) anc_z_q <= CW'($signed(cfg_i.start_val));
      if (cmd_i.keep) count_q <= count_q + 1'b1;
      if (cmd_i.drop) begin
        rel_x_q <= anc_x_q;
        rel_y_q <= anc_y_q;
        rel_z_q <= anc_z_q;
        anc_x_q <= sec_x_q;
        anc_y_q <= sec_y_q;
        // A leveled second point lands exactly on the old anchor height.
        if (!pass_q) anc_z_q <= sec_z_q;
        head_q  <= (head_q == AW'(WindowMax - 1)) ? '0 : head_q + 1'b1;
        count_q <= count_q - 1'b1;
      end
    end
  end

  assign sts_o.mul_busy = (b_q != '0);
  assign sts_o.keep_ok  = (dist_q >= lim_q) && (count_q < CNW'(WindowMax));
  assign sts_o.full     = (count_q >= winc);
  assign sts_o.pass     = pass_q;
  assign sts_o.sh_more  = (k_q < count_q);

  assign rel_x_o = 32'(rel_x_q);
  assign rel_y_o = 32'(rel_y_q);
  assign rel_z_o = 32'(rel_z_q);

endmodule

// ===== sv/floor_drift_leveler_core.sv =====
// Top level of the floor drift leveler: stream ports, APB port and output register.
// An item takes four multiplies (three squared differences and the squared separation);
// a release adds five multiplies for the gradient test and, when the test passes, a shift
// of the stored points.
// Throughput: one item at a time, the next accepted the cycle after the result loads.
// Reset: asynchronous, active low; the track holds only the start point afterwards.
module floor_drift_leveler_core #(
  parameter int WINDOW_MAX  = flr_pkg::WINDOW_MAX_DEF,
  parameter int COORD_WIDTH = flr_pkg::COORD_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Input transfer: pos_x [31:0], pos_y [63:32], pos_z [95:64].
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [95:0]                     s_axis_tdata,
  // Result transfer: out_x [31:0], out_y [63:32], out_z [95:64].
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [95:0]                     m_axis_tdata,
  // Result flags: kept [0], emitted [1].
  output logic [1:0]                      m_axis_tuser,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [flr_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [flr_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [flr_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);

  flr_pkg::cfg_t    cfg;
  flr_pkg::dp_cmd_t cmd;
  flr_pkg::dp_sts_t sts;
  flr_pkg::res_t    res;
  logic             out_free;
  logic             m_valid_q, m_valid_d;
  logic [95:0]      m_data_q;
  logic [1:0]       m_user_q;
  logic [31:0]      rel_x, rel_y, rel_z;

  assign pready = 1'b1;

  flr_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .cfg_o     (cfg)
  );

  flr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_free_i (out_free),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .res_o      (res)
  );

  flr_dp #(
    .WindowMax  (WINDOW_MAX),
    .CoordWidth (COORD_WIDTH)
  ) u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .cmd_i   (cmd),
    .in_x_i  (s_axis_tdata[31:0]),
    .in_y_i  (s_axis_tdata[63:32]),
    .in_z_i  (s_axis_tdata[95:64]),
    .sts_o   (sts),
    .rel_x_o (rel_x),
    .rel_y_o (rel_y),
    .rel_z_o (rel_z)
  );

  // The output register lets the next item enter while a result waits.
  assign out_free = !m_valid_q || m_axis_tready;

  always_comb begin
    m_valid_d = m_valid_q;
    if (res.load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.load) begin
      m_data_q <= {rel_z, rel_y, rel_x};
      m_user_q <= {res.emitted, res.kept};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // Only one item is in work: the input closes right after a transfer.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while an item is in work");

  // A released point always comes from a kept position.
  a_emit_needs_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[1] && !m_axis_tuser[0]))
    else $error("emitted without kept");

  // A new result never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.load |-> (!m_valid_q || m_axis_tready))
    else $error("result register overwritten");

endmodule

// ===== tb/floor_drift_leveler_checker.sv =====
// Checker for the floor drift leveler: predicts every result transfer and compares it.
module floor_drift_leveler_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [95:0]                    s_axis_tdata,
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [95:0]                    m_axis_tdata,
  input  logic [1:0]                     m_axis_tuser,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic                           pready,
  input  logic [flr_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [flr_pkg::APB_DATA_W-1:0] pwdata,
  output int                             fail_count,
  output int                             pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TRACK_DEPTH = flr_pkg::WINDOW_MAX_DEF;
  localparam longint Z_HI = 64'sd2147483647;
  localparam longint Z_LO = -64'sd2147483648;

  typedef struct {
    logic        kept;
    logic        emitted;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } fix_t;

  fix_t   fix_q[$];
  int     win_len;
  longint thr;
  longint min_sep;
  longint trk_x[TRACK_DEPTH];
  longint trk_y[TRACK_DEPTH];
  longint trk_z[TRACK_DEPTH];
  int     npts;
  longint rel_x, rel_y, rel_z;

  function automatic logic [127:0] sq_diff(longint a, longint b);
    longint d;
    logic [63:0] m;
    d = a - b;
    m = (d < 0) ? -d : d;
    return 128'(m) * 128'(m);
  endfunction

  function automatic longint clamp_z(longint v);
    if (v > Z_HI) return Z_HI;
    if (v < Z_LO) return Z_LO;
    return v;
  endfunction

  // Advances the track by one position and returns the result it causes.
  function automatic fix_t level_step(logic [95:0] pos);
    longint px, py, pz, shift;
    int win, n;
    logic [127:0] gap_sq, lim, h2, vz;
    fix_t r;
    px = longint'($signed(pos[31:0]));
    py = longint'($signed(pos[63:32]));
    pz = longint'($signed(pos[95:64]));
    win = win_len;
    if (win < 2) win = 2;
    if (win > TRACK_DEPTH) win = TRACK_DEPTH;
    r.kept = 1'b0;
    r.emitted = 1'b0;
    gap_sq = sq_diff(trk_x[npts-1], px) + sq_diff(trk_y[npts-1], py)
           + sq_diff(trk_z[npts-1], pz);
    lim = 128'(min_sep) * 128'(min_sep);
    if (gap_sq >= lim && npts < TRACK_DEPTH) begin
      r.kept = 1'b1;
      trk_x[npts] = px;
      trk_y[npts] = py;
      trk_z[npts] = pz;
      npts++;
      if (npts >= win) begin
        n = npts - 1;
        h2 = (sq_diff(trk_x[n], trk_x[1]) + sq_diff(trk_y[n], trk_y[1]))
           * (128'(thr) * 128'(thr));
        vz = sq_diff(trk_z[n], trk_z[1]) << 32;
        if (vz < h2) begin
          shift = trk_z[0] - trk_z[1];
          for (int i = 1; i <= n; i++) trk_z[i] = clamp_z(trk_z[i] + shift);
        end
        rel_x = trk_x[0];
        rel_y = trk_y[0];
        rel_z = trk_z[0];
        r.emitted = 1'b1;
        for (int i = 0; i < n; i++) begin
          trk_x[i] = trk_x[i+1];
          trk_y[i] = trk_y[i+1];
          trk_z[i] = trk_z[i+1];
        end
        npts = n;
      end
    end
    r.x = rel_x[31:0];
    r.y = rel_y[31:0];
    r.z = rel_z[31:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    fix_t want;
    if (!rst_ni) begin
      win_len = flr_pkg::WIN_RST;
      thr = flr_pkg::THR_RST;
      min_sep = flr_pkg::SEP_RST;
      for (int i = 0; i < TRACK_DEPTH; i++) begin
        trk_x[i] = 0;
        trk_y[i] = 0;
        trk_z[i] = 0;
      end
      npts = 1;
      rel_x = 0;
      rel_y = 0;
      rel_z = 0;
      fix_q.delete();
      fail_count = 0;
      pending = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          flr_pkg::REG_WINDOW:  win_len = pwdata[flr_pkg::WIN_W-1:0];
          flr_pkg::REG_THRESH:  thr = pwdata[flr_pkg::THR_W-1:0];
          flr_pkg::REG_MIN_SEP: min_sep = pwdata[flr_pkg::SEP_W-1:0];
          flr_pkg::REG_START_X: trk_x[0] = longint'($signed(pwdata));
          flr_pkg::REG_START_Y: trk_y[0] = longint'($signed(pwdata));
          flr_pkg::REG_START_Z: trk_z[0] = longint'($signed(pwdata));
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (fix_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result transfer, actual %h/%h", $realtime,
                   m_axis_tuser, m_axis_tdata);
        end else begin
          want = fix_q[0];
          fix_q.delete(0);
          if ({want.emitted, want.kept} !== m_axis_tuser ||
              {want.z, want.y, want.x} !== m_axis_tdata) begin
            fail_count++;
            $display("%0t: mismatch: expected kept=%b emitted=%b x=%h y=%h z=%h",
                     $realtime, want.kept, want.emitted, want.x, want.y, want.z);
            $display("%0t:           actual kept=%b emitted=%b x=%h y=%h z=%h",
                     $realtime, m_axis_tuser[0], m_axis_tuser[1], m_axis_tdata[31:0],
                     m_axis_tdata[63:32], m_axis_tdata[95:64]);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) fix_q.insert(fix_q.size(), level_step(s_axis_tdata));
      pending = fix_q.size();
    end
  end

endmodule

// ===== tb/floor_drift_leveler_core_test.sv =====
// Testbench top for the floor drift leveler: stimulus, configuration and verdict.
module floor_drift_leveler_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  // The limit lies well above the length of the whole run, receiver stalls included.
  localparam int CYCLE_LIMIT = 3000000;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  // Fields from bit 0 up: pos_x, pos_y, pos_z.
  logic [95:0]           s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  // Fields from bit 0 up: out_x, out_y, out_z.
  logic [95:0]           m_axis_tdata;
  // Fields from bit 0 up: kept, emitted.
  logic [1:0]            m_axis_tuser;
  logic                  psel, penable, pwrite, pready;
  logic [flr_pkg::APB_ADDR_W-1:0] paddr;
  logic [flr_pkg::APB_DATA_W-1:0] pwdata, prdata;

  int fail_count;
  int pending;
  int cycles;
  bit long_hold;
  bit send_burst;
  bit recv_burst;

  // The generator walks from the last position so that most items are kept.
  logic [31:0] walk_x, walk_y, walk_z;

  floor_drift_leveler_core u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  floor_drift_leveler_checker u_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .fail_count, .pending
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** floor_drift_leveler_core: FAILED **");
      $finish;
    end
  end

  // Register write with a setup phase and an access phase; the register takes the value at the access edge.
  // An idle phase follows so that back-to-back writes never collide.
  task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= flr_pkg::APB_ADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic cfg_all(logic [4:0] win, logic [23:0] thr, logic [30:0] sep,
                         logic [31:0] sx, logic [31:0] sy, logic [31:0] sz);
    cfg_write(flr_pkg::REG_WINDOW, 32'(win));
    cfg_write(flr_pkg::REG_THRESH, 32'(thr));
    cfg_write(flr_pkg::REG_MIN_SEP, 32'(sep));
    cfg_write(flr_pkg::REG_START_X, sx);
    cfg_write(flr_pkg::REG_START_Y, sy);
    cfg_write(flr_pkg::REG_START_Z, sz);
  endtask

  // Offers one position and holds it until the block takes the transfer.
  // tvalid stays high across back-to-back items so it gets one assignment per step.
  task automatic send_pos(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    int gap;
    if ($urandom_range(0, 15) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {z, y, x};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // The checker counts the last transfer at the same edge, so the task lets that edge
  // pass before it trusts the pending count.
  task automatic idle_sender();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    // The output register is loaded only once the item is finished, so the block is
    // already idle before the next register write.
    repeat (8) @(posedge clk_i);
  endtask

  function automatic logic [31:0] signed_step(int span);
    return 32'($signed(int'($urandom_range(0, 2 * span)) - span));
  endfunction

  // Mostly well-formed walks: level moves that can be leveled, steep moves that
  // fail the gradient test, tiny moves that get ignored, and full-range noise.
  task automatic send_random();
    int kind;
    logic [31:0] dx, dy;
    int hsum;
    kind = $urandom_range(0, 99);
    if (kind < 65) begin
      dx = signed_step(32'h30000);
      dy = signed_step(32'h30000);
      hsum = ($signed(dx) < 0 ? -$signed(dx) : $signed(dx)) / 16 + 1;
      walk_x = walk_x + dx;
      walk_y = walk_y + dy;
      walk_z = walk_z + signed_step(hsum);
      send_pos(walk_x, walk_y, walk_z);
    end else if (kind < 75) begin
      walk_x = walk_x + signed_step(32'h100);
      walk_z = walk_z + signed_step(32'h40000);
      send_pos(walk_x, walk_y, walk_z);
    end else if (kind < 85) begin
      send_pos(walk_x + signed_step(32'h100), walk_y + signed_step(32'h100),
               walk_z + signed_step(32'h100));
    end else if (kind < 90) begin
      // Pure vertical move: no horizontal change never levels.
      walk_z = walk_z + signed_step(32'h80000);
      send_pos(walk_x, walk_y, walk_z);
    end else begin
      walk_x = $urandom;
      walk_y = $urandom;
      walk_z = $urandom;
      send_pos(walk_x, walk_y, walk_z);
    end
  endtask

  task automatic random_run(int n);
    for (int i = 0; i < n; i++) send_random();
  endtask

  // Receiver: random stalls with bursts of none, and one long hold on request.
  initial begin
    int gap;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (long_hold) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
        long_hold = 1'b0;
      end
      if ($urandom_range(0, 15) == 0) recv_burst = !recv_burst;
      gap = recv_burst ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  initial begin
    cycles        <= 0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    long_hold     = 1'b0;
    send_burst    = 1'b0;
    recv_burst    = 1'b0;
    walk_x        = '0;
    walk_y        = '0;
    walk_z        = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: a repeat of the start point is ignored, then extremes,
    // a level walk that fills the window and a vertical move.
    send_pos(32'h0, 32'h0, 32'h0);
    send_pos(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send_pos(32'h80000000, 32'h80000000, 32'h80000000);
    for (int i = 1; i <= 9; i++) send_pos(32'(i) << 16, 32'(i) << 15, 32'(i) << 11);
    send_pos(32'd9 << 16, 32'd9 << 15, 32'h00400000);
    idle_sender();

    // A large leveling shift pushes later z values past the top and saturates.
    cfg_all(5'd3, 24'hffffff, 31'd0, 32'h80000000, 32'h7fffffff, 32'h7fff0000);
    send_pos(32'h00010000, 32'h0, 32'h80010000);
    send_pos(32'h00020000, 32'h0, 32'h80020000);
    send_pos(32'h00030000, 32'h0, 32'h80030000);
    send_pos(32'h00040000, 32'h0, 32'h80040000);
    walk_x = 32'h00040000;
    walk_y = 32'h0;
    walk_z = 32'h80040000;
    random_run(40);
    idle_sender();

    // Window below range acts as two; zero threshold never levels; huge separation.
    cfg_all(5'd0, 24'd0, 31'h7fffffff, 32'h0, 32'h0, 32'h0);
    send_pos(32'h7fffffff, 32'h80000000, 32'h7fffffff);
    send_pos(32'h80000000, 32'h7fffffff, 32'h80000000);
    random_run(60);
    idle_sender();

    // Window above range acts as the maximum; the receiver holds off for a long
    // stretch while items keep coming, so the block fills and stalls its input.
    cfg_all(5'd31, 24'd6554, 31'd16384, $urandom, $urandom, $urandom);
    walk_x = '0;
    walk_y = '0;
    walk_z = '0;
    random_run(40);
    long_hold = 1'b1;
    random_run(130);
    idle_sender();

    // Fill a large window, then shrink it while full.
    cfg_all(5'd16, 24'd3000, 31'd32768, 32'h0, 32'h0, 32'h0);
    random_run(150);
    idle_sender();
    cfg_write(flr_pkg::REG_WINDOW, 32'd3);
    cfg_write(flr_pkg::REG_THRESH, 32'd20000);
    random_run(80);
    // The sender waits until every expected result has come.
    idle_sender();
    random_run(80);
    idle_sender();

    cfg_all(5'd2, 24'd6554, 31'd32768, 32'h0, 32'h0, 32'h0);
    random_run(150);
    idle_sender();

    cfg_all(5'($urandom_range(2, 16)), 24'($urandom), 31'($urandom_range(0, 32'h20000)),
            $urandom, $urandom, $urandom);
    random_run(200);

    idle_sender();
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("** floor_drift_leveler_core: PASSED **");
    end else begin
      $display("** floor_drift_leveler_core: FAILED **");
    end
    $finish;
  end

endmodule

// ===== floor_drift_leveler_core.f =====
sv/flr_pkg.sv
sv/flr_cfg.sv
sv/flr_ctrl.sv
sv/flr_dp.sv
sv/floor_drift_leveler_core.sv
tb/floor_drift_leveler_checker.sv
tb/floor_drift_leveler_core_test.sv
